// ----- rtl/core/ilfs_pkg.sv -----
`timescale 1ns / 1ps
package ilfs_pkg;
    localparam int MaxVertices   = 9;
    localparam int RatioFracBits = 16;
    localparam int VW            = $clog2(MaxVertices);
    localparam int CntW          = $clog2(MaxVertices + 1);
    localparam int Pairs         = MaxVertices * (MaxVertices - 1) / 2;
    localparam int PairW         = $clog2(Pairs + 1);
    localparam int RecipW        = 15;
    localparam int NumW          = 4 + RatioFracBits + 12;
    localparam int QW            = 20;
    localparam logic [6:0] CharBias = 7'd63;
    localparam logic [11:0] RecipScale = 12'd2520;

    typedef logic [MaxVertices-1:0] vset_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BITS,
        ST_DEG,
        ST_SUB,
        ST_CHK,
        ST_COMP,
        ST_REACH,
        ST_CONN,
        ST_DIV,
        ST_OUT
    } state_t;

    // 2520/(d+1) for d = 0..15
    function automatic logic [11:0] recip_of(input logic [CntW-1:0] d);
        logic [11:0] r;
        unique case (d)
            0: r = 12'd2520;  1: r = 12'd1260;  2: r = 12'd840;  3: r = 12'd630;
            4: r = 12'd504;   5: r = 12'd420;   6: r = 12'd360;  7: r = 12'd315;
            8: r = 12'd280;   9: r = 12'd252;   10: r = 12'd229; 11: r = 12'd210;
            12: r = 12'd193;  13: r = 12'd180;  14: r = 12'd168; 15: r = 12'd157;
            default: r = 12'd0;
        endcase
        return r;
    endfunction

    function automatic logic [CntW-1:0] popcnt(input vset_t x);
        logic [CntW-1:0] c;
        c = '0;
        for (int i = 0; i < MaxVertices; i++)
            c = c + CntW'(x[i]);
        return c;
    endfunction
endpackage

// ----- rtl/core/ilfs_divider.sv -----
`timescale 1ns / 1ps
module ilfs_divider
    import ilfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [NumW-1:0]   num,
    input  logic [RecipW-1:0] den,
    output logic              done,
    output logic [NumW-1:0]   quo
);
    localparam int StepW = $clog2(NumW + 1);
    logic [NumW-1:0]   q_reg, q_next;
    logic [RecipW:0]   r_reg, r_next;
    logic [StepW-1:0]  n_reg, n_next;
    logic              busy_reg, busy_next;
    logic [RecipW:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = {r_reg[RecipW-1:0], q_reg[NumW-1]};
        if (go)
        begin
            q_next = num;
            r_next = '0;
            n_next = StepW'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[NumW-2:0], 1'b0};
            if (trial >= {1'b0, den})
            begin
                r_next = trial - {1'b0, den};
                q_next[0] = 1'b1;
            end
            else
                r_next = trial;
            n_next = n_reg - 1'b1;
            if (n_reg == StepW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = busy_reg && (n_reg == StepW'(1));
    assign quo  = q_next;
endmodule

// ----- rtl/core/induced_linear_forest_search_unit.sv -----
`timescale 1ns / 1ps
// Channel | Ports                                   | Dir | Handshake
// cmd     | code_char, last                         | in  | start & !busy
// result  | vertex_count, forest_size,              | out | done strobe
//         | recip_sum_scaled, ratio_q16,            |     |
//         | is_connected, size_error                |     |
// A header char needs only the accept; an adjacency char the accept, then one bit
// per cycle. A last char adds the degree sum over n vertices, then the subset sweep:
// per subset a size test, a degree check over up to n vertices, and for survivors
// one seed step per component plus one per frontier step, the settling step included.
// Degree sum and check share one row/popcount unit. Then a connectivity pass, a
// restoring divide and the result state.
// Reset clears all control and the adjacency rows. Results cannot stall.
module induced_linear_forest_search_unit
    import ilfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [6:0]         code_char,
    input  logic               last,
    output logic               busy,
    output logic               done,
    output logic [5:0]         vertex_count,
    output logic [3:0]         forest_size,
    output logic [RecipW-1:0]  recip_sum_scaled,
    output logic [QW-1:0]      ratio_q16,
    output logic               is_connected,
    output logic               size_error
);
    state_t state_reg, state_next;
    vset_t  adj_reg [MaxVertices];
    vset_t  adj_next [MaxVertices];
    logic [5:0]  nv_reg, nv_next;
    logic [PairW-1:0] pc_reg, pc_next;
    logic [VW-1:0] row_reg, row_next, col_reg, col_next;
    logic        first_reg, first_next;
    logic        last_reg, last_next;
    logic [5:0]  bits_reg, bits_next;
    logic [2:0]  bi_reg, bi_next;
    logic [VW-1:0] v_reg, v_next;
    logic [RecipW-1:0] recip_reg, recip_next;
    vset_t  mask_reg, mask_next, full_reg, full_next;
    vset_t  rest_reg, rest_next, reach_reg, reach_next;
    logic [CntW:0]   e2_reg, e2_next;
    logic [CntW-1:0] comps_reg, comps_next, best_reg, best_next;
    logic        conn_reg, conn_next;
    logic [QW-1:0] ratio_reg;
    logic [NumW-1:0] num;
    logic        div_go, div_done;
    logic [NumW-1:0] quo;
    vset_t       row_sel, grow;
    logic [CntW-1:0] rowcnt, setcnt;
    logic [5:0]  val;
    logic        err;
    logic        last_v;
    logic [PairW:0] pair_prod;
    logic [PairW-1:0] pairs;
    logic        advance;

    assign val = 6'(code_char - CharBias);
    assign err = (nv_reg == 6'd0) || (nv_reg > 6'(MaxVertices));
    assign pair_prod = {1'b0, nv_reg} * {1'b0, nv_reg - 6'd1};
    assign pairs = pair_prod[PairW:1];
    assign last_v = ({2'b00, v_reg} + 6'd1) == nv_reg;
    assign row_sel = adj_reg[v_reg];
    assign rowcnt = popcnt(row_sel & ((state_reg == ST_DEG) ? full_reg : mask_reg));
    assign setcnt = popcnt(mask_reg);
    assign num = (NumW'(best_reg) * NumW'(RecipScale)) << RatioFracBits;

    // one frontier expansion: OR of rows of reached vertices (independent lanes)
    always_comb
    begin
        grow = reach_reg;
        for (int i = 0; i < MaxVertices; i++)
            if (reach_reg[i])
                grow = grow | (adj_reg[i] & mask_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        adj_next = adj_reg;
        nv_next = nv_reg; pc_next = pc_reg; row_next = row_reg; col_next = col_reg;
        first_next = first_reg; last_next = last_reg; bits_next = bits_reg;
        bi_next = bi_reg; v_next = v_reg; recip_next = recip_reg;
        mask_next = mask_reg; full_next = full_reg; rest_next = rest_reg;
        reach_next = reach_reg; e2_next = e2_reg; comps_next = comps_reg;
        best_next = best_reg; conn_next = conn_reg; div_go = 1'b0;
        advance = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = last;
                    if (first_reg)
                    begin
                        nv_next = val;
                        first_next = 1'b0;
                        state_next = last ? ST_DEG : ST_IDLE;
                        full_next = vset_t'((16'd1 << val[3:0]) - 16'd1);
                        v_next = '0;
                        recip_next = '0;
                    end
                    else
                    begin
                        bits_next = val;
                        bi_next = 3'd6;
                        state_next = ST_BITS;
                    end
                end
            end
            ST_BITS:
            begin
                if (!err && pc_reg < pairs)
                begin
                    if (bits_reg[5])
                    begin
                        adj_next[row_reg][col_reg] = 1'b1;
                        adj_next[col_reg][row_reg] = 1'b1;
                    end
                    pc_next = pc_reg + 1'b1;
                    if (row_reg + 1'b1 == col_reg)
                    begin
                        row_next = '0;
                        col_next = col_reg + 1'b1;
                    end
                    else
                        row_next = row_reg + 1'b1;
                end
                bits_next = {bits_reg[4:0], 1'b0};
                bi_next = bi_reg - 1'b1;
                if (bi_reg == 3'd1)
                begin
                    state_next = last_reg ? ST_DEG : ST_IDLE;
                    v_next = '0;
                    recip_next = '0;
                end
            end
            ST_DEG:
            begin
                if (err)
                    state_next = ST_OUT;
                else
                begin
                    recip_next = recip_reg + RecipW'(recip_of(rowcnt));
                    if (last_v)
                    begin
                        mask_next = vset_t'(1);
                        best_next = '0;
                        state_next = ST_SUB;
                    end
                    else
                        v_next = v_reg + 1'b1;
                end
            end
            ST_SUB:
            begin
                if (setcnt <= best_reg)
                    advance = 1'b1;
                else
                begin
                    v_next = '0;
                    e2_next = '0;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (mask_reg[v_reg] && rowcnt > CntW'(2))
                    advance = 1'b1;
                else
                begin
                    if (mask_reg[v_reg])
                        e2_next = e2_reg + {1'b0, rowcnt};
                    if (last_v)
                    begin
                        rest_next = mask_reg;
                        comps_next = '0;
                        state_next = ST_COMP;
                    end
                    else
                        v_next = v_reg + 1'b1;
                end
            end
            ST_COMP:
            begin
                if (rest_reg == '0)
                begin
                    // acyclic iff edges + components == vertices
                    if ((e2_reg >> 1) + {1'b0, comps_reg} == {1'b0, setcnt})
                        best_next = setcnt;
                    advance = 1'b1;
                end
                else
                begin
                    reach_next = rest_reg & ~(rest_reg - vset_t'(1));
                    comps_next = comps_reg + 1'b1;
                    state_next = ST_REACH;
                end
            end
            ST_REACH:
            begin
                reach_next = grow;
                if (grow == reach_reg)
                begin
                    rest_next = rest_reg & ~reach_reg;
                    state_next = ST_COMP;
                end
            end
            ST_CONN:
            begin
                reach_next = grow;
                if (grow == reach_reg)
                begin
                    conn_next = (reach_reg == full_reg);
                    div_go = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
                for (int i = 0; i < MaxVertices; i++)
                    adj_next[i] = '0;
                nv_next = '0; pc_next = '0; row_next = '0;
                col_next = VW'(1); first_next = 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase

        // next subset, or the connectivity pass after the full set
        if (advance)
        begin
            if (mask_reg == full_reg)
            begin
                mask_next = full_reg;
                reach_next = vset_t'(1);
                state_next = ST_CONN;
            end
            else
            begin
                mask_next = mask_reg + vset_t'(1);
                state_next = ST_SUB;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < MaxVertices; i++)
                adj_reg[i] <= '0;
            nv_reg <= '0; pc_reg <= '0; row_reg <= '0; col_reg <= VW'(1);
            first_reg <= 1'b1; last_reg <= 1'b0; bi_reg <= '0; v_reg <= '0;
            mask_reg <= '0; best_reg <= '0; comps_reg <= '0; e2_reg <= '0;
            bits_reg <= '0; recip_reg <= '0; full_reg <= '0;
            rest_reg <= '0; reach_reg <= '0; conn_reg <= 1'b0;
            ratio_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            adj_reg <= adj_next;
            nv_reg <= nv_next; pc_reg <= pc_next; row_reg <= row_next;
            col_reg <= col_next; first_reg <= first_next; last_reg <= last_next;
            bi_reg <= bi_next; v_reg <= v_next; mask_reg <= mask_next;
            best_reg <= best_next; comps_reg <= comps_next; e2_reg <= e2_next;
            bits_reg <= bits_next; recip_reg <= recip_next; full_reg <= full_next;
            rest_reg <= rest_next; reach_reg <= reach_next; conn_reg <= conn_next;
            if (div_done)
                ratio_reg <= QW'(quo);
        end
    end

    ilfs_divider u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go),
        .num(num), .den(recip_reg), .done(div_done), .quo(quo)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_OUT);
    assign vertex_count = nv_reg;
    assign size_error = err;
    assign forest_size = err ? 4'd0 : 4'(best_reg);
    assign recip_sum_scaled = err ? '0 : recip_reg;
    assign ratio_q16 = err ? '0 : ratio_reg;
    assign is_connected = err ? 1'b0 : conn_reg;
endmodule

// ----- bench/induced_linear_forest_search_unit_test.sv -----
`timescale 1ns / 1ps
module induced_linear_forest_search_unit_test;
    import ilfs_pkg::*;

    typedef struct {
        logic [6:0] code;
        logic       fin;
        bit         hold;
    } char_t;

    typedef struct {
        logic [5:0]        vcount;
        logic [3:0]        fsize;
        logic [RecipW-1:0] recip;
        logic [QW-1:0]     ratio;
        logic              conn;
        logic              err;
    } forest_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic [6:0]        code_char;
    logic              last;
    logic              busy;
    logic              done;
    logic [5:0]        vertex_count;
    logic [3:0]        forest_size;
    logic [RecipW-1:0] recip_sum_scaled;
    logic [QW-1:0]     ratio_q16;
    logic              is_connected;
    logic              size_error;

    induced_linear_forest_search_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .code_char(code_char), .last(last),
        .busy(busy), .done(done), .vertex_count(vertex_count), .forest_size(forest_size),
        .recip_sum_scaled(recip_sum_scaled), .ratio_q16(ratio_q16),
        .is_connected(is_connected), .size_error(size_error)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    char_t          graph_chars[$];
    forest_result_t forest_results[$];
    int             mismatches = 0;

    // shadow of the decoder state
    vset_t       adj_rows[MaxVertices];
    int unsigned n_verts;
    int unsigned pair_pos;
    int unsigned char_pos;

    function automatic int unsigned ones(input vset_t x);
        int unsigned c;
        c = 0;
        for (int i = 0; i < MaxVertices; i++)
            c += x[i];
        return c;
    endfunction

    function automatic vset_t reach_set(input int unsigned seed, input vset_t scope);
        vset_t r;
        vset_t p;
        r = '0;
        r[seed] = 1'b1;
        p = '0;
        while (r != p)
        begin
            p = r;
            for (int v = 0; v < n_verts; v++)
                if (r[v])
                    r |= adj_rows[v] & scope;
        end
        return r;
    endfunction

    function automatic bit linear_forest(input vset_t s);
        int unsigned deg_sum;
        int unsigned comps;
        int unsigned d;
        int unsigned low;
        vset_t       rest;
        deg_sum = 0;
        comps = 0;
        for (int v = 0; v < n_verts; v++)
            if (s[v])
            begin
                d = ones(adj_rows[v] & s);
                if (d > 2)
                    return 0;
                deg_sum += d;
            end
        rest = s;
        while (rest != '0)
        begin
            low = 0;
            while (!rest[low])
                low++;
            rest &= ~reach_set(low, s);
            comps++;
        end
        return deg_sum / 2 + comps == ones(s);
    endfunction

    function automatic void clear_graph();
        for (int v = 0; v < MaxVertices; v++)
            adj_rows[v] = '0;
        n_verts = 0;
        pair_pos = 0;
        char_pos = 0;
    endfunction

    function automatic void place_bit(input bit b);
        int unsigned row;
        int unsigned col;
        if (pair_pos >= n_verts * (n_verts - 1) / 2)
            return;
        row = pair_pos;
        col = 1;
        while (row >= col)
        begin
            row -= col;
            col++;
        end
        if (b)
        begin
            adj_rows[row][col] = 1'b1;
            adj_rows[col][row] = 1'b1;
        end
        pair_pos++;
    endfunction

    function automatic void predict_char(input char_t c);
        logic [5:0]     val;
        forest_result_t r;
        vset_t          full;
        int unsigned    rsum;
        int unsigned    best;
        longint unsigned q;
        val = 6'(c.code - 7'd63);
        if (char_pos == 0)
            n_verts = val;
        else if (n_verts != 0 && n_verts <= MaxVertices)
            for (int k = 5; k >= 0; k--)
                place_bit(val[k]);
        if (char_pos < 15)
            char_pos++;
        if (!c.fin)
            return;
        r = '{6'(n_verts), 0, 0, 0, 0, 0};
        if (n_verts == 0 || n_verts > MaxVertices)
            r.err = 1'b1;
        else
        begin
            full = vset_t'((1 << n_verts) - 1);
            rsum = 0;
            for (int v = 0; v < n_verts; v++)
                rsum += 2520 / (ones(adj_rows[v] & full) + 1);
            best = 0;
            for (int m = 1; m <= full; m++)
                if (ones(vset_t'(m)) > best && linear_forest(vset_t'(m)))
                    best = ones(vset_t'(m));
            q = ((longint'(best) << RatioFracBits) * 2520) / rsum;
            r.fsize = 4'(best);
            r.recip = RecipW'(rsum);
            r.ratio = QW'(q);
            r.conn = reach_set(0, full) == full;
        end
        forest_results.push_back(r);
        clear_graph();
    endfunction

    function automatic void add_char(input int code, input bit fin, input bit hold = 0);
        char_t c;
        c.code = 7'(code);
        c.fin = fin;
        c.hold = hold;
        graph_chars.push_back(c);
    endfunction

    // header then adj_count adjacency chars; last on the final one
    function automatic void add_graph(input int head, input int adj_count, input bit noisy,
                                      input bit hold = 0);
        add_char(head, adj_count == 0, hold);
        for (int i = 0; i < adj_count; i++)
            add_char(noisy ? $urandom_range(0, 127) : 63 + $urandom_range(0, 63),
                     i == adj_count - 1);
    endfunction

    // sender: bursts with random gaps
    int unsigned gap_left;
    int unsigned burst_left;
    always @(posedge clk or negedge rst_n)
    begin
        bit ready;
        if (!rst_n)
        begin
            start <= 1'b0;
            code_char <= 7'd0;
            last <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_char(graph_chars.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                ready = graph_chars.size() > 0 && gap_left == 0 &&
                        !(graph_chars[0].hold && forest_results.size() > 0);
                start <= ready;
                if (ready)
                begin
                    code_char <= graph_chars[0].code;
                    last <= graph_chars[0].fin;
                end
            end
        end
    end

    // results cannot be stalled; check every strobe
    always @(posedge clk)
    begin
        forest_result_t e;
        if (rst_n && done)
        begin
            if (forest_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: n=%0d", vertex_count);
            end
            else
            begin
                e = forest_results.pop_front();
                if (vertex_count !== e.vcount || forest_size !== e.fsize ||
                    recip_sum_scaled !== e.recip || ratio_q16 !== e.ratio ||
                    is_connected !== e.conn || size_error !== e.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp n=%0d f=%0d r=%0d q=%0d c=%0d e=%0d",
                                  " | got n=%0d f=%0d r=%0d q=%0d c=%0d e=%0d"},
                                 e.vcount, e.fsize, e.recip, e.ratio, e.conn, e.err,
                                 vertex_count, forest_size, recip_sum_scaled, ratio_q16,
                                 is_connected, size_error);
                end
            end
        end
    end

    initial
    begin
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int n;
        int r;
        int adj;
        clear_graph();
        rst_n = 1'b0;
        // directed graphs
        add_graph(63, 0, 0);                 // zero vertices
        add_graph(64, 0, 0);                 // single vertex
        add_char(65, 0); add_char(63 + 32, 1);
        add_char(72, 0); repeat (5) add_char(126, 0); add_char(126, 1);  // K9
        add_char(72, 0); repeat (5) add_char(63, 0); add_char(63, 1);    // empty 9
        add_char(72, 0); add_char(126, 0); add_char(126, 1);             // short string
        add_char(68, 0); repeat (3) add_char(126, 0); add_char(126, 1);  // surplus bits
        add_char(73, 0); add_char(126, 0); add_char(126, 1);             // too many vertices
        add_graph(126, 0, 0);                // n = 63
        add_char(0, 0); add_char(127, 1);    // wrapped header
        add_char(72, 0); add_char(0, 0); add_char(127, 1);
        // random graphs; first waits for an empty pipeline
        r = 0;
        while (graph_chars.size() < 140)
        begin
            n = $urandom_range(1, MaxVertices);
            adj = (n * (n - 1) / 2 + 5) / 6;
            case ($urandom_range(0, 9))
                0: add_graph($urandom_range(0, 127), $urandom_range(0, 3), 1, r == 0);
                1: add_graph(63 + n, $urandom_range(0, 18), $urandom_range(0, 1), r == 0);
                default: add_graph(63 + n, adj, 0, r == 0);
            endcase
            r++;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (graph_chars.size() > 0 || forest_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && forest_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/ilfs_pkg.sv
rtl/core/ilfs_divider.sv
rtl/core/induced_linear_forest_search_unit.sv
bench/induced_linear_forest_search_unit_test.sv
